// ===== sv/mqf_pkg.sv =====
// Package for the multi-queue FIFO unit: command, status and state codes,
// payload field widths and default parameter values. No dependencies.
package mqf_pkg;

  localparam int unsigned CMD_W    = 2;
  localparam int unsigned SEL_W    = 2;
  localparam int unsigned WORD_W   = 32;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned LOST_W   = 32;

  localparam int unsigned DEF_QUEUE_DEPTH = 16;
  localparam int unsigned DEF_NUM_QUEUES  = 4;
  localparam int unsigned DEF_WORD_WIDTH  = 32;

  typedef enum logic [CMD_W-1:0] {
    CMD_CLEAR = 2'd0,
    CMD_READ  = 2'd1,
    CMD_WRITE = 2'd2
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOOK,
    S_FETCH,
    S_DONE
  } state_e;

endpackage

// ===== sv/mqf_if.sv =====
// Valid/ready channel interfaces for the multi-queue FIFO unit: the command
// channel and the result channel. Depends on mqf_pkg for field widths.
interface mqf_in_if;
  import mqf_pkg::*;

  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  cmd;
  logic [SEL_W-1:0]  queue_sel;
  logic [WORD_W-1:0] write_word;

  modport source (output valid, output cmd, output queue_sel, output write_word,
                  input ready);
  modport sink   (input valid, input cmd, input queue_sel, input write_word,
                  output ready);
endinterface

interface mqf_out_if;
  import mqf_pkg::*;

  logic                valid;
  logic                ready;
  logic [WORD_W-1:0]   read_word;
  logic [STATUS_W-1:0] status;
  logic [LOST_W-1:0]   lost_count;

  modport source (output valid, output read_word, output status, output lost_count,
                  input ready);
  modport sink   (input valid, input read_word, input status, input lost_count,
                  output ready);
endinterface

// ===== sv/multi_queue_fifo_unit.sv =====
// Multi-queue FIFO unit: a bank of circular word FIFOs held in two memories.
// A command is captured with its queue's control entry, then goes through the
// read-modify-write of the queue control memory and, for a read that returns
// a word, the dependent data memory read. No new command is taken until its
// result is loaded into the output register. Reset empties all queues at once
// through per-queue valid bits; data words are not cleared.
module multi_queue_fifo_unit #(
  parameter int unsigned QUEUE_DEPTH = mqf_pkg::DEF_QUEUE_DEPTH,
  parameter int unsigned NUM_QUEUES  = mqf_pkg::DEF_NUM_QUEUES,
  parameter int unsigned WORD_WIDTH  = mqf_pkg::DEF_WORD_WIDTH
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  mqf_in_if.sink     in_i,
  mqf_out_if.source  out_o
);
  import mqf_pkg::*;

  localparam int unsigned PTR_W     = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W     = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned QIDX_W    = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
  localparam int unsigned MEM_DEPTH = NUM_QUEUES * QUEUE_DEPTH;
  localparam int unsigned ADDR_W    = $clog2(MEM_DEPTH);
  localparam int unsigned STORE_W   = (WORD_WIDTH < WORD_W) ? WORD_WIDTH : WORD_W;

  localparam logic [PTR_W-1:0]  PTR_LAST  = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0]  CNT_FULL  = CNT_W'(QUEUE_DEPTH);
  localparam logic [ADDR_W-1:0] QUEUE_SPAN = ADDR_W'(QUEUE_DEPTH);

  typedef struct packed {
    logic [PTR_W-1:0]  rd_ptr;
    logic [PTR_W-1:0]  wr_ptr;
    logic [CNT_W-1:0]  occ;
    logic [LOST_W-1:0] lost;
  } qctl_t;

  // Memories.
  qctl_t               ctl_mem  [NUM_QUEUES];
  logic [STORE_W-1:0]  data_mem [MEM_DEPTH];
  logic [NUM_QUEUES-1:0] ctl_vld_q;
  qctl_t               ctl_rdata_q;
  logic                ctl_hit_q;
  logic [STORE_W-1:0]  data_rdata_q;

  // Captured command.
  cmd_e                cmd_q;
  logic [QIDX_W-1:0]   qidx_q;
  logic                in_range_q;
  logic [WORD_W-1:0]   word_q;

  state_e              state_q, state_d;

  // Pending result and output register.
  logic [WORD_W-1:0]   res_word_q;
  status_e             res_status_q;
  logic [LOST_W-1:0]   res_lost_q;
  logic                out_valid_q;
  logic [WORD_W-1:0]   out_word_q;
  status_e             out_status_q;
  logic [LOST_W-1:0]   out_lost_q;

  logic                in_acc;
  logic                in_range_in;
  logic [QIDX_W-1:0]   in_qidx;
  logic                out_ld;
  qctl_t               cur;
  qctl_t               nxt;
  logic                ctl_we;
  logic                data_we;
  logic                data_re;
  status_e             look_status;
  logic [LOST_W-1:0]   look_lost;
  logic [PTR_W-1:0]    data_ptr;
  logic [ADDR_W-1:0]   data_addr;

  function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] p);
    next_slot = (p == PTR_LAST) ? '0 : p + PTR_W'(1);
  endfunction

  assign in_i.ready  = (state_q == S_IDLE);
  assign in_acc      = in_i.valid && in_i.ready;
  assign in_qidx     = QIDX_W'(in_i.queue_sel);
  assign in_range_in = (32'(in_i.queue_sel) < NUM_QUEUES);
  assign out_ld      = (state_q == S_DONE) && (!out_valid_q || out_o.ready);

  // A queue whose valid bit is clear has had no control memory write since reset.
  assign cur = ctl_hit_q ? ctl_rdata_q : '0;

  always_comb begin
    nxt         = cur;
    ctl_we      = 1'b0;
    data_we     = 1'b0;
    data_re     = 1'b0;
    look_status = STAT_OK;
    data_ptr    = cur.wr_ptr;
    if ((state_q == S_LOOK) && in_range_q) begin
      unique case (cmd_q)
        CMD_CLEAR: begin
          nxt    = '0;
          ctl_we = 1'b1;
        end
        CMD_READ: begin
          data_ptr = cur.rd_ptr;
          if (cur.occ == '0) begin
            look_status = STAT_EMPTY;
          end else begin
            nxt.rd_ptr = next_slot(cur.rd_ptr);
            nxt.occ    = cur.occ - CNT_W'(1);
            ctl_we     = 1'b1;
            data_re    = 1'b1;
          end
        end
        CMD_WRITE: begin
          if (cur.occ >= CNT_FULL) begin
            nxt.lost    = cur.lost + LOST_W'(1);
            look_status = STAT_FULL;
            ctl_we      = 1'b1;
          end else begin
            nxt.wr_ptr = next_slot(cur.wr_ptr);
            nxt.occ    = cur.occ + CNT_W'(1);
            ctl_we     = 1'b1;
            data_we    = 1'b1;
          end
        end
        default: begin
          nxt = cur;
        end
      endcase
    end
    look_lost = in_range_q ? nxt.lost : '0;
  end

  assign data_addr = ADDR_W'(qidx_q) * QUEUE_SPAN + ADDR_W'(data_ptr);

  // Sequencer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) state_d = S_LOOK;
      end
      S_LOOK: begin
        state_d = data_re ? S_FETCH : S_DONE;
      end
      S_FETCH: begin
        state_d = S_DONE;
      end
      S_DONE: begin
        if (out_ld) state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Command capture and control memory read.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      cmd_q       <= cmd_e'(in_i.cmd);
      qidx_q      <= in_qidx;
      in_range_q  <= in_range_in;
      word_q      <= in_i.write_word;
      ctl_rdata_q <= ctl_mem[in_qidx];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_hit_q <= 1'b0;
      ctl_vld_q <= '0;
    end else begin
      if (in_acc) ctl_hit_q <= in_range_in && ctl_vld_q[in_qidx];
      if (ctl_we) ctl_vld_q[qidx_q] <= 1'b1;
    end
  end

  // Memory writes and the data memory read.
  always_ff @(posedge clk_i) begin
    if (ctl_we) ctl_mem[qidx_q] <= nxt;
    if (data_we) data_mem[data_addr] <= word_q[STORE_W-1:0];
    if (data_re) data_rdata_q <= data_mem[data_addr];
  end

  // Pending result.
  always_ff @(posedge clk_i) begin
    if (state_q == S_LOOK) begin
      res_word_q   <= '0;
      res_status_q <= look_status;
      res_lost_q   <= look_lost;
    end else if (state_q == S_FETCH) begin
      res_word_q   <= WORD_W'(data_rdata_q);
    end
  end

  // Output register: holds a finished result until the sink takes it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_ld) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_ld) begin
      out_word_q   <= res_word_q;
      out_status_q <= res_status_q;
      out_lost_q   <= res_lost_q;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.read_word  = out_word_q;
  assign out_o.status     = out_status_q;
  assign out_o.lost_count = out_lost_q;

`ifndef ASSERT_OFF
  a_fetch_after_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_FETCH |-> $past(state_q) == S_LOOK && cmd_q == CMD_READ)
    else $error("data fetch without a read command");

  a_occ_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_LOOK && in_range_q |-> cur.occ <= CNT_FULL)
    else $error("queue occupancy beyond depth");

  a_empty_ptrs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_LOOK && in_range_q && cur.occ == '0 |-> cur.rd_ptr == cur.wr_ptr)
    else $error("empty queue with unequal pointers");

  a_no_word_on_fail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_status_q != STAT_OK |-> out_word_q == '0)
    else $error("failed command returned a word");
`endif

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 100ps
// Testbench for multi_queue_fifo_unit: a directed table, then random command traffic.
// Depends on mqf_pkg, mqf_in_if, mqf_out_if and the unit itself.
module testbench;
  import mqf_pkg::*;

  localparam int unsigned NUM_Q = DEF_NUM_QUEUES;
  localparam int unsigned DEPTH = DEF_QUEUE_DEPTH;
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  localparam int RANDOM_ITEMS     = 700;
  localparam int HOLD_AT_ITEM     = 180;
  localparam int PAUSE_AT_ITEM    = 420;
  localparam int LONG_HOLD_CYCLES = 300;
  localparam int DRAIN_CYCLES     = 12;
  localparam int CYCLE_LIMIT      = 300000;

  typedef struct packed {
    logic [WORD_W-1:0] read_word;
    status_e           status;
    logic [LOST_W-1:0] lost_count;
  } fifo_result_t;

  typedef struct {
    logic [CMD_W-1:0]  cmd;
    logic [SEL_W-1:0]  sel;
    logic [WORD_W-1:0] word;
    int                reps;
    bit                typed;
    fifo_result_t      want;
  } stim_row_t;

  logic clk;
  logic rst_n;
  int   cycle_count = 0;
  int   err_count = 0;
  bit   long_hold_req = 1'b0;
  int   burst_left = 0;

  // Shadow copy of the queue bank.
  logic [WORD_W-1:0] shadow_mem [NUM_Q][DEPTH];
  int                head_ptr [NUM_Q];
  int                tail_ptr [NUM_Q];
  int                fill_level [NUM_Q];
  logic [LOST_W-1:0] drop_count [NUM_Q];

  fifo_result_t pending_results [$];
  stim_row_t    directed_rows [$];

  mqf_in_if  cmd_ch ();
  mqf_out_if res_ch ();

  multi_queue_fifo_unit DUT (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (cmd_ch.sink),
    .out_o  (res_ch.source)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("testbench: done, errors");
    $finish;
  end

  function automatic fifo_result_t apply_queue_command(logic [CMD_W-1:0] c,
                                                       logic [SEL_W-1:0] s,
                                                       logic [WORD_W-1:0] w);
    fifo_result_t r;
    int q;
    r = '{read_word: '0, status: STAT_OK, lost_count: '0};
    q = int'(s);
    if (q < NUM_Q) begin
      case (c)
        CMD_CLEAR: begin
          head_ptr[q] = 0;
          tail_ptr[q] = 0;
          fill_level[q] = 0;
          drop_count[q] = '0;
        end
        CMD_READ: begin
          if (fill_level[q] == 0) begin
            r.status = STAT_EMPTY;
          end else begin
            r.read_word = shadow_mem[q][head_ptr[q]];
            head_ptr[q] = (head_ptr[q] == DEPTH - 1) ? 0 : head_ptr[q] + 1;
            fill_level[q]--;
          end
        end
        CMD_WRITE: begin
          if (fill_level[q] >= DEPTH) begin
            drop_count[q] = drop_count[q] + 1'b1;
            r.status = STAT_FULL;
          end else begin
            shadow_mem[q][tail_ptr[q]] = w;
            tail_ptr[q] = (tail_ptr[q] == DEPTH - 1) ? 0 : tail_ptr[q] + 1;
            fill_level[q]++;
          end
        end
        default: begin
        end
      endcase
      r.lost_count = drop_count[q];
    end
    return r;
  endfunction

  function automatic void add_row(logic [CMD_W-1:0] c, logic [SEL_W-1:0] s,
                                  logic [WORD_W-1:0] w, int n, bit typed,
                                  logic [WORD_W-1:0] rw, status_e st,
                                  logic [LOST_W-1:0] lc);
    stim_row_t row;
    row.cmd = c;
    row.sel = s;
    row.word = w;
    row.reps = n;
    row.typed = typed;
    row.want.read_word = rw;
    row.want.status = st;
    row.want.lost_count = lc;
    directed_rows.push_back(row);
  endfunction

  // Offers one command and waits for its transaction; the expectation is
  // queued at the accepting edge.
  task automatic send_command(logic [CMD_W-1:0] c, logic [SEL_W-1:0] s,
                              logic [WORD_W-1:0] w, bit typed, fifo_result_t want);
    fifo_result_t pred;
    cmd_ch.valid      <= 1'b1;
    cmd_ch.cmd        <= c;
    cmd_ch.queue_sel  <= s;
    cmd_ch.write_word <= w;
    do @(posedge clk); while (cmd_ch.ready !== 1'b1);
    pred = apply_queue_command(c, s, w);
    pending_results.push_back(typed ? want : pred);
  endtask

  // Bursts of back-to-back commands separated by random gaps.
  task automatic pace_sender();
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      burst_left = $urandom_range(1, 24);
      if (gap > 0) begin
        cmd_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
  endtask

  task automatic wait_drained();
    cmd_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  initial begin : result_sink
    int rx_cycle;
    int stall_left;
    rx_cycle = 0;
    stall_left = 0;
    res_ch.ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      rx_cycle++;
      if (long_hold_req) begin
        res_ch.ready <= 1'b0;
        repeat (LONG_HOLD_CYCLES) @(posedge clk);
        long_hold_req = 1'b0;
        res_ch.ready <= 1'b1;
      end else if (stall_left > 0) begin
        res_ch.ready <= 1'b0;
        stall_left--;
      end else if ((rx_cycle % 512) < 150) begin
        res_ch.ready <= 1'b1;
      end else if ($urandom_range(0, 3) == 0) begin
        res_ch.ready <= 1'b0;
        stall_left = $urandom_range(0, 6);
      end else begin
        res_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : result_check
    fifo_result_t want;
    if (rst_n === 1'b1 && res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, got word %h status %0d lost %0d",
                 $time, res_ch.read_word, res_ch.status, res_ch.lost_count);
        err_count++;
      end else begin
        want = pending_results.pop_front();
        if (res_ch.read_word !== want.read_word) begin
          $display("%0t: read_word expected %h, got %h", $time, want.read_word,
                   res_ch.read_word);
          err_count++;
        end
        if (res_ch.status !== want.status) begin
          $display("%0t: status expected %0d, got %0d", $time, want.status,
                   res_ch.status);
          err_count++;
        end
        if (res_ch.lost_count !== want.lost_count) begin
          $display("%0t: lost_count expected %0d, got %0d", $time, want.lost_count,
                   res_ch.lost_count);
          err_count++;
        end
      end
    end
  end

  initial begin : command_source
    stim_row_t         row;
    logic [CMD_W-1:0]  c;
    logic [SEL_W-1:0]  s;
    logic [WORD_W-1:0] w;
    int                fill_bias;
    int                focus_q;
    int                roll;

    rst_n = 1'b0;
    cmd_ch.valid = 1'b0;
    cmd_ch.cmd = CMD_CLEAR;
    cmd_ch.queue_sel = '0;
    cmd_ch.write_word = '0;
    for (int q = 0; q < NUM_Q; q++) begin
      head_ptr[q] = 0;
      tail_ptr[q] = 0;
      fill_level[q] = 0;
      drop_count[q] = '0;
    end
    fill_bias = 50;
    focus_q = 0;

    add_row(CMD_READ,   2'd0, 32'h0000_0000,  1, 1'b1, 32'h0000_0000, STAT_EMPTY, 0);
    add_row(CMD_WRITE,  2'd0, 32'hFFFF_FFFF,  1, 1'b1, 32'h0000_0000, STAT_OK,    0);
    add_row(CMD_READ,   2'd0, 32'h0000_0000,  1, 1'b1, 32'hFFFF_FFFF, STAT_OK,    0);
    add_row(CMD_CLEAR,  2'd2, 32'hFFFF_FFFF,  1, 1'b1, 32'h0000_0000, STAT_OK,    0);
    // Fill queue 3 to one short of full, then take the last slot.
    add_row(CMD_WRITE,  2'd3, 32'h0000_0100, 15, 1'b0, '0,            STAT_OK,    0);
    add_row(CMD_WRITE,  2'd3, 32'h0000_0000,  1, 1'b1, 32'h0000_0000, STAT_OK,    0);
    // Writes to a full queue are dropped and counted.
    add_row(CMD_WRITE,  2'd3, 32'hA5A5_A5A5,  1, 1'b1, 32'h0000_0000, STAT_FULL,  1);
    add_row(CMD_WRITE,  2'd3, 32'h5A5A_5A5A,  1, 1'b1, 32'h0000_0000, STAT_FULL,  2);
    add_row(CMD_UNUSED, 2'd3, 32'h1234_5678,  1, 1'b1, 32'h0000_0000, STAT_OK,    2);
    add_row(CMD_READ,   2'd3, 32'h0000_0000,  1, 1'b1, 32'h0000_0100, STAT_OK,    2);
    add_row(CMD_CLEAR,  2'd3, 32'h0000_0000,  1, 1'b1, 32'h0000_0000, STAT_OK,    0);
    add_row(CMD_READ,   2'd3, 32'h0000_0000,  1, 1'b1, 32'h0000_0000, STAT_EMPTY, 0);

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      for (int k = 0; k < row.reps; k++) begin
        pace_sender();
        send_command(row.cmd, row.sel, row.word + k, row.typed, row.want);
      end
    end

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == HOLD_AT_ITEM) long_hold_req = 1'b1;
      // Each stretch leans toward filling or draining one favored queue.
      if (n % 60 == 0) begin
        fill_bias = $urandom_range(15, 90);
        focus_q = $urandom_range(0, NUM_Q - 1);
      end
      roll = $urandom_range(0, 99);
      if (roll < 3) c = CMD_CLEAR;
      else if (roll < 5) c = CMD_UNUSED;
      else if ($urandom_range(0, 99) < fill_bias) c = CMD_WRITE;
      else c = CMD_READ;
      s = SEL_W'(($urandom_range(0, 99) < 65) ? focus_q : $urandom_range(0, NUM_Q - 1));
      roll = $urandom_range(0, 9);
      if (roll == 0) w = '0;
      else if (roll == 1) w = '1;
      else w = $urandom;
      if (n == PAUSE_AT_ITEM) wait_drained();
      else pace_sender();
      send_command(c, s, w, 1'b0, '0);
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_count == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule

// ===== multi_queue_fifo_unit.f =====
sv/mqf_pkg.sv
sv/mqf_if.sv
sv/multi_queue_fifo_unit.sv
tb/sv/testbench.sv
